// File: hw/rtl/lps_pkg.sv
// lps_pkg: shared constants, codes and types of the led pattern sequencer
// used by lps_channel and led_pattern_sequencer_unit, depends on nothing else
package lps_pkg;

    localparam int PROGRAM_DEPTH = 64;
    localparam int NUM_CHANNELS  = 2;

    localparam int MASK_W  = 2;
    localparam int ADDR_W  = 6;
    localparam int CODE_W  = 4;
    localparam int REQ_W   = 2;
    localparam int WAIT_W  = 10;
    localparam int CFG_AW  = 2;
    localparam int MEM_AW  = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
    localparam int IDX_W   = $clog2(PROGRAM_DEPTH + 1);

    localparam int IN_FIELDS_W  = 1 + ADDR_W + CODE_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * MASK_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [WAIT_W-1:0] WAIT_SHORT = WAIT_W'(10);
    localparam logic [WAIT_W-1:0] WAIT_100   = WAIT_W'(100);
    localparam logic [WAIT_W-1:0] WAIT_200   = WAIT_W'(200);
    localparam logic [WAIT_W-1:0] WAIT_500   = WAIT_W'(500);
    localparam logic [WAIT_W-1:0] WAIT_1000  = WAIT_W'(1000);

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_START = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [CODE_W-1:0] {
        ACT_END     = 4'd0,
        ACT_ON      = 4'd1,
        ACT_OFF     = 4'd2,
        ACT_DLY100  = 4'd3,
        ACT_DLY200  = 4'd4,
        ACT_DLY500  = 4'd5,
        ACT_DLY1000 = 4'd6,
        ACT_REPEAT  = 4'd7
    } t_action;

    typedef enum logic [CFG_AW-1:0] {
        CFG_PRESENT  = 2'd0,
        CFG_MODE_OFF = 2'd1,
        CFG_INVERT   = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [IN_DATA_W-IN_FIELDS_W-1:0] pad;
        logic [CODE_W-1:0]                action_code;
        logic [ADDR_W-1:0]                prog_addr;
        logic                             led_sel;
    } t_in_data;

    typedef struct packed {
        logic [OUT_DATA_W-OUT_FIELDS_W-1:0] pad;
        logic [MASK_W-1:0]                  running_mask;
        logic [MASK_W-1:0]                  pin_levels;
    } t_out_data;

    typedef struct packed {
        logic              tick;
        logic              wr;
        logic              start;
        logic [ADDR_W-1:0] addr;
        logic [CODE_W-1:0] code;
    } t_chan_cmd;

    typedef struct packed {
        logic led_on;
        logic running;
    } t_chan_stat;

endpackage

// File: hw/rtl/lps_channel.sv
// lps_channel: one led channel, program memory, countdown and action decode
// depends on lps_pkg
module lps_channel (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  lps_pkg::t_chan_cmd i_cmd,
    input  logic               i_present,
    input  logic               i_mode_off,
    output lps_pkg::t_chan_stat o_next
);

    logic [lps_pkg::CODE_W-1:0] mem [lps_pkg::PROGRAM_DEPTH];

    logic [lps_pkg::IDX_W-1:0]  r_idx,  n_idx;
    logic [lps_pkg::WAIT_W-1:0] r_wait, n_wait;
    logic                       r_run,  n_run;
    logic                       r_led,  n_led;
    logic [lps_pkg::CODE_W-1:0] r_code;
    logic [lps_pkg::CODE_W-1:0] code_eff;

    logic                       wr_en;
    logic [lps_pkg::MEM_AW-1:0] wr_addr;
    logic [lps_pkg::MEM_AW-1:0] rd_addr;

    assign wr_en   = i_fire && i_cmd.wr && (int'(i_cmd.addr) < lps_pkg::PROGRAM_DEPTH);
    assign wr_addr = lps_pkg::MEM_AW'(i_cmd.addr);
    // read ahead at the index the next beat will see
    assign rd_addr = i_rst_n ? n_idx[lps_pkg::MEM_AW-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_cmd.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            r_code <= i_cmd.code;
        end else begin
            r_code <= mem[rd_addr];
        end
    end

    assign code_eff = (r_idx < lps_pkg::IDX_W'(lps_pkg::PROGRAM_DEPTH))
                      ? r_code : lps_pkg::ACT_END;

    always_comb begin
        n_idx  = r_idx;
        n_wait = r_wait;
        n_run  = r_run;
        n_led  = r_led;
        if (i_fire) begin
            if (i_cmd.tick && r_run) begin
                if (r_wait > lps_pkg::WAIT_W'(1)) begin
                    n_wait = r_wait - lps_pkg::WAIT_W'(1);
                end else begin
                    n_wait = '0;
                    if (i_mode_off) begin
                        n_led = 1'b0;
                        n_run = 1'b0;
                    end else begin
                        case (code_eff)
                            lps_pkg::ACT_END: begin
                                n_idx = '0;
                                n_run = 1'b0;
                            end
                            lps_pkg::ACT_ON: begin
                                n_led  = 1'b1;
                                n_wait = lps_pkg::WAIT_SHORT;
                                n_idx  = r_idx + lps_pkg::IDX_W'(1);
                            end
                            lps_pkg::ACT_OFF: begin
                                n_led  = 1'b0;
                                n_wait = lps_pkg::WAIT_SHORT;
                                n_idx  = r_idx + lps_pkg::IDX_W'(1);
                            end
                            lps_pkg::ACT_DLY100: begin
                                n_wait = lps_pkg::WAIT_100;
                                n_idx  = r_idx + lps_pkg::IDX_W'(1);
                            end
                            lps_pkg::ACT_DLY200: begin
                                n_wait = lps_pkg::WAIT_200;
                                n_idx  = r_idx + lps_pkg::IDX_W'(1);
                            end
                            lps_pkg::ACT_DLY500: begin
                                n_wait = lps_pkg::WAIT_500;
                                n_idx  = r_idx + lps_pkg::IDX_W'(1);
                            end
                            lps_pkg::ACT_DLY1000: begin
                                n_wait = lps_pkg::WAIT_1000;
                                n_idx  = r_idx + lps_pkg::IDX_W'(1);
                            end
                            lps_pkg::ACT_REPEAT: begin
                                n_idx  = '0;
                                n_wait = lps_pkg::WAIT_SHORT;
                            end
                            default: begin
                                n_wait = lps_pkg::WAIT_SHORT;
                                n_idx  = r_idx + lps_pkg::IDX_W'(1);
                            end
                        endcase
                    end
                end
            end else if (i_cmd.start && i_present) begin
                if (i_mode_off) begin
                    n_led = 1'b0;
                end else begin
                    n_idx  = '0;
                    n_wait = lps_pkg::WAIT_SHORT;
                    n_run  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_wait <= '0;
            r_run  <= 1'b0;
            r_led  <= 1'b0;
        end else begin
            r_idx  <= n_idx;
            r_wait <= n_wait;
            r_run  <= n_run;
            r_led  <= n_led;
        end
    end

    assign o_next.led_on  = n_led;
    assign o_next.running = n_run;

    a_run_has_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_wait != '0))
        else $error("running channel with zero wait");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= lps_pkg::IDX_W'(lps_pkg::PROGRAM_DEPTH))
        else $error("action index beyond program depth");

    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_cmd.tick && i_cmd.start && i_present && !i_mode_off)
        |=> (r_run && (r_idx == '0) && (r_wait == lps_pkg::WAIT_SHORT)))
        else $error("start did not load channel");

endmodule

// File: hw/rtl/led_pattern_sequencer_unit.sv
// led_pattern_sequencer_unit: top level, beat input register, config registers,
// channel instances and result register; depends on lps_pkg and lps_channel
// an accepted beat waits in the input register until the result register is free
// throughput: one beat per cycle, unless m_axis_tready stalls the result register
// reset: synchronous, clears handshake state, channel state and config registers
// program memory is not cleared and holds unknown codes until written
module led_pattern_sequencer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lps_pkg::IN_DATA_W-1:0] s_axis_tdata,  // led_sel, prog_addr, action_code
    input  logic [lps_pkg::REQ_W-1:0]     s_axis_tuser,  // req_type
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lps_pkg::OUT_DATA_W-1:0] m_axis_tdata, // pin_levels, running_mask
    input  logic                          i_cfg_we,
    input  logic [lps_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [lps_pkg::MASK_W-1:0]    i_cfg_wdata
);

    logic                          r_in_valid;
    lps_pkg::t_in_data             r_in_data;
    logic [lps_pkg::REQ_W-1:0]     r_in_user;
    logic                          r_out_valid;
    lps_pkg::t_out_data            r_out_data, n_out_data;
    logic [lps_pkg::MASK_W-1:0]    r_present, r_mode_off, r_invert;

    logic                          proc_fire;
    logic                          in_fire;
    lps_pkg::t_chan_cmd            cmd [lps_pkg::NUM_CHANNELS];
    lps_pkg::t_chan_stat           stat [lps_pkg::NUM_CHANNELS];

    assign proc_fire     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || proc_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_data <= lps_pkg::t_in_data'(s_axis_tdata);
            r_in_user <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present  <= '0;
            r_mode_off <= '0;
            r_invert   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                lps_pkg::CFG_PRESENT:  r_present  <= i_cfg_wdata;
                lps_pkg::CFG_MODE_OFF: r_mode_off <= i_cfg_wdata;
                lps_pkg::CFG_INVERT:   r_invert   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < lps_pkg::NUM_CHANNELS; g++) begin : g_chan
        logic hit;
        logic present;
        logic mode_off;

        assign hit = (int'(r_in_data.led_sel) == g);
        if (g < lps_pkg::MASK_W) begin : g_mask
            assign present  = r_present[g];
            assign mode_off = r_mode_off[g];
        end else begin : g_nomask
            assign present  = 1'b0;
            assign mode_off = 1'b0;
        end

        assign cmd[g].tick  = (r_in_user == lps_pkg::REQ_TICK);
        assign cmd[g].wr    = (r_in_user == lps_pkg::REQ_WRITE) && hit;
        assign cmd[g].start = (r_in_user == lps_pkg::REQ_START) && hit;
        assign cmd[g].addr  = r_in_data.prog_addr;
        assign cmd[g].code  = r_in_data.action_code;

        lps_channel u_chan (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_fire     (proc_fire),
            .i_cmd      (cmd[g]),
            .i_present  (present),
            .i_mode_off (mode_off),
            .o_next     (stat[g])
        );
    end

    for (genvar b = 0; b < lps_pkg::MASK_W; b++) begin : g_out
        if (b < lps_pkg::NUM_CHANNELS) begin : g_used
            assign n_out_data.pin_levels[b]   = stat[b].led_on ^ r_invert[b];
            assign n_out_data.running_mask[b] = stat[b].running;
        end else begin : g_unused
            assign n_out_data.pin_levels[b]   = 1'b0;
            assign n_out_data.running_mask[b] = 1'b0;
        end
    end
    assign n_out_data.pad = '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire |=> m_axis_tvalid)
        else $error("processed beat without result");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_in_valid)
        else $error("accepted beat not held in input register");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !proc_fire) |-> !s_axis_tready)
        else $error("input register overwritten while stalled");

endmodule
